// File: src/stps_pkg.sv
package stps_pkg;

    localparam int SLOTS_DEFAULT = 16;
    localparam int COUNT_W       = 32;
    localparam int SLOT_FIELD_W  = 4;

    typedef enum logic [1:0] {
        ST_FREE     = 2'd0,
        ST_RUNNABLE = 2'd1,
        ST_RUNNING  = 2'd2,
        ST_SLEEPING = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        ACT_TICK     = 2'd0,
        ACT_SLEEP    = 2'd1,
        ACT_EXIT     = 2'd2,
        ACT_ACTIVATE = 2'd3
    } action_t;

    // One slot-table entry as it is stored in the memory.
    typedef struct packed {
        status_t              st;
        logic [COUNT_W-1:0]   cnt;
    } entry_t;

    typedef struct packed {
        logic                    switched;
        logic [SLOT_FIELD_W-1:0] current_slot;
    } res_t;

endpackage

// File: src/stps_mem.sv
module stps_mem #(
    parameter int DEPTH = stps_pkg::SLOTS_DEFAULT,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 wr_en,
    input  logic [AW-1:0]        wr_addr,
    input  stps_pkg::entry_t     wr_data,
    input  logic                 rd_en,
    input  logic [AW-1:0]        rd_addr,
    output stps_pkg::entry_t     rd_data
);

    stps_pkg::entry_t ram [DEPTH];
    stps_pkg::entry_t rd_q_reg;
    logic             rd_vld_reg;
    // An entry never written since reset reads as a free slot with a zero count.
    logic [DEPTH-1:0] vld_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            ram[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_q_reg <= ram[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end else begin
            if (rd_en) begin
                rd_vld_reg <= vld_reg[rd_addr];
            end
            if (wr_en) begin
                vld_reg[wr_addr] <= 1'b1;
            end
        end
    end

    assign rd_data = rd_vld_reg ? rd_q_reg : '0;

endmodule

// File: src/stps_seq.sv
module stps_seq #(
    parameter int SLOTS = stps_pkg::SLOTS_DEFAULT,
    parameter int IW    = $clog2(SLOTS)
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  stps_pkg::action_t                in_action,
    input  logic [stps_pkg::COUNT_W-1:0]     in_ticks,
    input  logic [stps_pkg::SLOT_FIELD_W-1:0] in_slot,
    input  logic                             out_ready,
    output logic                             res_valid,
    output stps_pkg::res_t                   res,
    output logic                             mem_wr_en,
    output logic [IW-1:0]                    mem_wr_addr,
    output stps_pkg::entry_t                 mem_wr_data,
    output logic                             mem_rd_en,
    output logic [IW-1:0]                    mem_rd_addr,
    input  stps_pkg::entry_t                 mem_rd_data
);

    localparam int XW = IW + stps_pkg::SLOT_FIELD_W;
    localparam logic [IW-1:0] LAST_IDX = IW'(SLOTS - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_FIX_NEXT,
        S_FIX_CUR,
        S_RESP
    } state_t;

    state_t                        state_reg;
    stps_pkg::action_t             act_reg;
    logic [stps_pkg::COUNT_W-1:0]  ticks_reg;
    logic                          tgt_ok_reg;
    logic [IW-1:0]                 tgt_idx_reg;
    logic [IW-1:0]                 run_reg;
    logic [IW-1:0]                 scan_idx_reg;
    logic                          found_reg;
    logic [IW-1:0]                 found_idx_reg;
    logic [stps_pkg::COUNT_W-1:0]  found_cnt_reg;
    stps_pkg::entry_t              cur_ent_reg;
    logic                          sw_reg;

    logic [XW-1:0]                 tgt_ext;
    logic [XW-1:0]                 run_ext;
    logic                          accept;
    logic                          hit_run;
    stps_pkg::entry_t              upd_ent;
    stps_pkg::entry_t              cur_fix;
    logic                          cur_fix_en;

    assign accept   = in_valid && in_ready;
    assign in_ready = (state_reg == S_IDLE);
    assign tgt_ext  = XW'(in_slot);
    assign hit_run  = (scan_idx_reg == run_reg);

    // Per-entry update applied as the scan streams through the table.
    always_comb begin
        upd_ent = mem_rd_data;
        unique case (act_reg)
            stps_pkg::ACT_TICK: begin
                if (mem_rd_data.st == stps_pkg::ST_SLEEPING) begin
                    if (mem_rd_data.cnt != '0) begin
                        upd_ent.cnt = mem_rd_data.cnt - 32'd1;
                    end
                    if (upd_ent.cnt == '0) begin
                        upd_ent.st = stps_pkg::ST_RUNNABLE;
                    end
                end
            end
            stps_pkg::ACT_SLEEP: begin
                if (hit_run && mem_rd_data.st == stps_pkg::ST_RUNNING) begin
                    upd_ent.st  = stps_pkg::ST_SLEEPING;
                    upd_ent.cnt = (ticks_reg == '0) ? 32'd1 : ticks_reg;
                end
            end
            stps_pkg::ACT_EXIT: begin
                if (hit_run && mem_rd_data.st == stps_pkg::ST_RUNNING) begin
                    upd_ent.st  = stps_pkg::ST_FREE;
                    upd_ent.cnt = '0;
                end
            end
            stps_pkg::ACT_ACTIVATE: begin
                if (tgt_ok_reg && scan_idx_reg == tgt_idx_reg &&
                    mem_rd_data.st == stps_pkg::ST_FREE) begin
                    upd_ent.st = stps_pkg::ST_RUNNABLE;
                end
            end
            default: ;
        endcase
    end

    // The current slot is demoted when another slot takes over, or promoted
    // when it is runnable and nothing else is.
    always_comb begin
        cur_fix    = cur_ent_reg;
        cur_fix_en = 1'b0;
        if (found_reg && cur_ent_reg.st == stps_pkg::ST_RUNNING) begin
            cur_fix.st = stps_pkg::ST_RUNNABLE;
            cur_fix_en = 1'b1;
        end else if (!found_reg && cur_ent_reg.st == stps_pkg::ST_RUNNABLE) begin
            cur_fix.st = stps_pkg::ST_RUNNING;
            cur_fix_en = 1'b1;
        end
    end

    always_comb begin
        mem_wr_en   = 1'b0;
        mem_wr_addr = scan_idx_reg;
        mem_wr_data = upd_ent;
        mem_rd_en   = 1'b0;
        mem_rd_addr = '0;
        unique case (state_reg)
            S_IDLE: begin
                mem_rd_en = accept;
            end
            S_SCAN: begin
                mem_wr_en   = 1'b1;
                mem_rd_en   = (scan_idx_reg != LAST_IDX);
                mem_rd_addr = scan_idx_reg + 1'b1;
            end
            S_FIX_NEXT: begin
                mem_wr_en   = found_reg;
                mem_wr_addr = found_idx_reg;
                mem_wr_data = '{st: stps_pkg::ST_RUNNING, cnt: found_cnt_reg};
            end
            S_FIX_CUR: begin
                mem_wr_en   = cur_fix_en;
                mem_wr_addr = run_reg;
                mem_wr_data = cur_fix;
            end
            S_RESP: ;
            default: ;
        endcase
    end

    assign run_ext          = XW'(run_reg);
    assign res.current_slot = run_ext[stps_pkg::SLOT_FIELD_W-1:0];
    assign res.switched     = sw_reg;
    assign res_valid        = (state_reg == S_RESP) && out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            run_reg   <= '0;
            found_reg <= 1'b0;
        end else begin
            unique case (state_reg)
                S_IDLE: begin
                    if (accept) begin
                        act_reg      <= in_action;
                        ticks_reg    <= in_ticks;
                        tgt_ok_reg   <= (tgt_ext < XW'(SLOTS));
                        tgt_idx_reg  <= tgt_ext[IW-1:0];
                        scan_idx_reg <= '0;
                        found_reg    <= 1'b0;
                        state_reg    <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (hit_run) begin
                        cur_ent_reg <= upd_ent;
                    end
                    if (!hit_run && !found_reg && upd_ent.st == stps_pkg::ST_RUNNABLE) begin
                        found_reg     <= 1'b1;
                        found_idx_reg <= scan_idx_reg;
                        found_cnt_reg <= upd_ent.cnt;
                    end
                    scan_idx_reg <= scan_idx_reg + 1'b1;
                    if (scan_idx_reg == LAST_IDX) begin
                        if (act_reg == stps_pkg::ACT_ACTIVATE) begin
                            sw_reg    <= 1'b0;
                            state_reg <= S_RESP;
                        end else begin
                            state_reg <= S_FIX_NEXT;
                        end
                    end
                end
                S_FIX_NEXT: begin
                    state_reg <= S_FIX_CUR;
                end
                S_FIX_CUR: begin
                    sw_reg <= found_reg;
                    if (found_reg) begin
                        run_reg <= found_idx_reg;
                    end
                    state_reg <= S_RESP;
                end
                S_RESP: begin
                    if (out_ready) begin
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

// File: src/sleep_timer_process_scheduler.sv
// Fixed-priority process scheduler with per-slot sleep countdowns.
//
// The input stream carries one command per beat: a tick, sleep of the
// current slot, exit of the current slot, or activation of a free slot.
// The result stream returns one beat per command with the slot running
// afterwards and a flag that is set when the running slot changed.
//
// The slot table lives in a single memory with a registered read port.
// Every command makes one read-modify-write pass over all SLOTS entries;
// a tick, sleep or exit then makes up to two fix-up writes that mark the
// chosen slot running and demote or promote the current one; an
// activation skips the fix-ups. The sweep over the table dominates the
// time each command takes. The next command is accepted in the cycle
// after the result enters the output register.
//
// Reset makes every slot free with a zero count and slot zero current,
// through per-entry valid bits, so no clearing pass is needed.
// When the receiver stalls, the result waits in the output register; one
// more command may be accepted and worked on, and it holds its own result
// until the register is free.
module sleep_timer_process_scheduler #(
    parameter int SLOTS = stps_pkg::SLOTS_DEFAULT
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [1:0] action, [33:2] sleep_ticks, [37:34] slot, [39:38] zero
    input  logic [39:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [3:0] current_slot, [4] switched, [7:5] zero
    output logic [7:0]  m_axis_tdata
);

    localparam int IW = $clog2(SLOTS);

    logic              out_ready;
    logic              res_valid;
    stps_pkg::res_t    res;
    logic              mem_wr_en;
    logic [IW-1:0]     mem_wr_addr;
    stps_pkg::entry_t  mem_wr_data;
    logic              mem_rd_en;
    logic [IW-1:0]     mem_rd_addr;
    stps_pkg::entry_t  mem_rd_data;

    logic              m_tvalid_reg;
    logic [7:0]        m_tdata_reg;

    assign out_ready = !m_tvalid_reg || m_axis_tready;

    stps_seq #(
        .SLOTS (SLOTS),
        .IW    (IW)
    ) u_seq (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (s_axis_tvalid),
        .in_ready    (s_axis_tready),
        .in_action   (stps_pkg::action_t'(s_axis_tdata[1:0])),
        .in_ticks    (s_axis_tdata[33:2]),
        .in_slot     (s_axis_tdata[37:34]),
        .out_ready   (out_ready),
        .res_valid   (res_valid),
        .res         (res),
        .mem_wr_en   (mem_wr_en),
        .mem_wr_addr (mem_wr_addr),
        .mem_wr_data (mem_wr_data),
        .mem_rd_en   (mem_rd_en),
        .mem_rd_addr (mem_rd_addr),
        .mem_rd_data (mem_rd_data)
    );

    stps_mem #(
        .DEPTH (SLOTS),
        .AW    (IW)
    ) u_mem (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            if (res_valid) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_axis_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid) begin
            m_tdata_reg <= {3'b000, res.switched, res.current_slot};
        end
    end

    assign m_axis_tvalid = m_tvalid_reg;
    assign m_axis_tdata  = m_tdata_reg;

endmodule

// File: tb/sv/sleep_timer_process_scheduler_test.sv
`timescale 1ns / 1ps

module sleep_timer_process_scheduler_test;

    localparam int SLOT_COUNT     = stps_pkg::SLOTS_DEFAULT;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int RANDOM_BEATS   = 1000;
    localparam int DRAIN_CYCLES   = 40;

    // Tracks the slot table and checks every result beat against it.
    class slot_schedule_board;
        stps_pkg::status_t                slot_state [SLOT_COUNT];
        logic [stps_pkg::COUNT_W-1:0]     slot_wait [SLOT_COUNT];
        logic [stps_pkg::SLOT_FIELD_W-1:0] current;
        stps_pkg::res_t                   expected_slots [$];
        int                               mismatches;

        function new();
            for (int i = 0; i < SLOT_COUNT; i++) begin
                slot_state[i] = stps_pkg::ST_FREE;
                slot_wait[i]  = '0;
            end
            current    = '0;
            mismatches = 0;
        endfunction

        function void reschedule_slots();
            logic [stps_pkg::SLOT_FIELD_W-1:0] chosen;
            bit                                found;
            chosen = current;
            found  = 1'b0;
            if (slot_state[current] == stps_pkg::ST_RUNNING)
                slot_state[current] = stps_pkg::ST_RUNNABLE;
            for (int i = 0; i < SLOT_COUNT; i++) begin
                if (!found && i != current && slot_state[i] == stps_pkg::ST_RUNNABLE) begin
                    chosen = i[stps_pkg::SLOT_FIELD_W-1:0];
                    found  = 1'b1;
                end
            end
            if (slot_state[chosen] == stps_pkg::ST_RUNNABLE)
                slot_state[chosen] = stps_pkg::ST_RUNNING;
            current = chosen;
        endfunction

        function void note_command(stps_pkg::action_t act,
                                   logic [stps_pkg::COUNT_W-1:0] ticks,
                                   logic [stps_pkg::SLOT_FIELD_W-1:0] target);
            logic [stps_pkg::SLOT_FIELD_W-1:0] prior;
            stps_pkg::res_t                    res;
            prior = current;
            case (act)
                stps_pkg::ACT_TICK: begin
                    for (int i = 0; i < SLOT_COUNT; i++) begin
                        if (slot_state[i] == stps_pkg::ST_SLEEPING) begin
                            if (slot_wait[i] != 0)
                                slot_wait[i] = slot_wait[i] - 1;
                            if (slot_wait[i] == 0)
                                slot_state[i] = stps_pkg::ST_RUNNABLE;
                        end
                    end
                    reschedule_slots();
                end
                stps_pkg::ACT_SLEEP: begin
                    if (slot_state[current] == stps_pkg::ST_RUNNING) begin
                        slot_state[current] = stps_pkg::ST_SLEEPING;
                        // A zero-tick sleep still waits for one tick.
                        slot_wait[current]  = (ticks == 0) ? 1 : ticks;
                    end
                    reschedule_slots();
                end
                stps_pkg::ACT_EXIT: begin
                    if (slot_state[current] == stps_pkg::ST_RUNNING) begin
                        slot_state[current] = stps_pkg::ST_FREE;
                        slot_wait[current]  = '0;
                    end
                    reschedule_slots();
                end
                default: begin
                    if (int'(target) < SLOT_COUNT &&
                        slot_state[target] == stps_pkg::ST_FREE)
                        slot_state[target] = stps_pkg::ST_RUNNABLE;
                end
            endcase
            res.current_slot = current;
            res.switched     = (current != prior);
            expected_slots.push_back(res);
        endfunction

        function void check_result(logic [7:0] beat);
            stps_pkg::res_t got;
            stps_pkg::res_t want;
            got = stps_pkg::res_t'(beat[4:0]);
            if (expected_slots.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: result beat slot=%0d switched=%0b with nothing expected",
                             $realtime, got.current_slot, got.switched);
            end else begin
                want = expected_slots.pop_front();
                if (got.current_slot !== want.current_slot ||
                    got.switched !== want.switched) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: expected slot=%0d switched=%0b, got slot=%0d switched=%0b",
                                 $realtime, want.current_slot, want.switched,
                                 got.current_slot, got.switched);
                end
            end
        endfunction

        function int pending();
            return expected_slots.size();
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [7:0]  m_axis_tdata;

    slot_schedule_board board;
    bit                 no_gaps;
    int                 idle_cycles;

    sleep_timer_process_scheduler #(
        .SLOTS(SLOT_COUNT)
    ) u_top (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    task automatic send_command(stps_pkg::action_t act,
                                logic [stps_pkg::COUNT_W-1:0] ticks,
                                logic [stps_pkg::SLOT_FIELD_W-1:0] target);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 4);
        repeat (gap) begin
            @(negedge aclk);
            s_axis_tvalid <= 1'b0;
        end
        @(negedge aclk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {2'b00, target, ticks, act};
        do @(posedge aclk); while (!s_axis_tready);
    endtask

    task automatic send_random_command();
        int                           pick;
        stps_pkg::action_t            act;
        logic [stps_pkg::COUNT_W-1:0] ticks;
        pick  = $urandom_range(0, 99);
        ticks = $urandom;
        if (pick < 30) begin
            act = stps_pkg::ACT_ACTIVATE;
        end else if (pick < 60) begin
            act = stps_pkg::ACT_TICK;
        end else if (pick < 80) begin
            act = stps_pkg::ACT_SLEEP;
            // Keep sleeps short so that slots keep waking up.
            ticks = ($urandom_range(0, 49) == 0) ? $urandom_range(9, 40)
                                                 : $urandom_range(0, 8);
        end else begin
            act = stps_pkg::ACT_EXIT;
        end
        send_command(act, ticks,
                     stps_pkg::SLOT_FIELD_W'($urandom_range(0, SLOT_COUNT - 1)));
    endtask

    // Result side: a random stall before each beat, none in steady stretches.
    initial begin
        int gap;
        m_axis_tready = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            gap = no_gaps ? 0 : $urandom_range(0, 4);
            repeat (gap) begin
                @(negedge aclk);
                m_axis_tready <= 1'b0;
            end
            @(negedge aclk);
            m_axis_tready <= 1'b1;
            do @(posedge aclk); while (!m_axis_tvalid);
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_axis_tvalid && s_axis_tready)
                board.note_command(stps_pkg::action_t'(s_axis_tdata[1:0]),
                                   s_axis_tdata[33:2], s_axis_tdata[37:34]);
            if (m_axis_tvalid && m_axis_tready)
                board.check_result(m_axis_tdata);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    initial begin
        board         = new();
        no_gaps       = 1'b0;
        idle_cycles   = 0;
        aresetn       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Nothing runnable yet, then sleep and exit of a slot that is not running.
        send_command(stps_pkg::ACT_TICK,     32'hAAAA_5555, 4'd0);
        send_command(stps_pkg::ACT_SLEEP,    32'd5,         4'd0);
        send_command(stps_pkg::ACT_EXIT,     32'h5555_AAAA, 4'd15);
        send_command(stps_pkg::ACT_ACTIVATE, 32'h0000_0000, 4'd0);
        send_command(stps_pkg::ACT_ACTIVATE, 32'hFFFF_FFFF, 4'd0);
        send_command(stps_pkg::ACT_TICK,     32'd0,         4'd0);
        send_command(stps_pkg::ACT_ACTIVATE, 32'd0,         4'd15);
        send_command(stps_pkg::ACT_ACTIVATE, 32'd0,         4'd3);
        send_command(stps_pkg::ACT_TICK,     32'd0,         4'd0);
        send_command(stps_pkg::ACT_SLEEP,    32'd0,         4'd0);
        send_command(stps_pkg::ACT_TICK,     32'd0,         4'd0);
        send_command(stps_pkg::ACT_SLEEP,    32'hFFFF_FFFF, 4'd0);
        send_command(stps_pkg::ACT_EXIT,     32'd0,         4'd0);
        send_command(stps_pkg::ACT_EXIT,     32'd0,         4'd0);
        send_command(stps_pkg::ACT_TICK,     32'd0,         4'd0);
        // The current slot is made runnable again and then revived by a sleep.
        send_command(stps_pkg::ACT_ACTIVATE, 32'd0,         4'd15);
        send_command(stps_pkg::ACT_SLEEP,    32'd2,         4'd0);
        send_command(stps_pkg::ACT_ACTIVATE, 32'd0,         4'd7);
        send_command(stps_pkg::ACT_SLEEP,    32'd1,         4'd0);
        send_command(stps_pkg::ACT_TICK,     32'd0,         4'd0);
        send_command(stps_pkg::ACT_SLEEP,    32'd2,         4'd0);
        send_command(stps_pkg::ACT_EXIT,     32'd0,         4'd0);
        send_command(stps_pkg::ACT_TICK,     32'd0,         4'd0);
        send_command(stps_pkg::ACT_TICK,     32'd0,         4'd0);

        for (int i = 0; i < RANDOM_BEATS; i++) begin
            no_gaps = ((i / 100) % 4 == 3);
            send_random_command();
        end
        no_gaps = 1'b0;
        @(negedge aclk);
        s_axis_tvalid <= 1'b0;

        while (board.pending() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (board.mismatches == 0 && board.pending() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// File: filelist.f
src/stps_pkg.sv
src/stps_mem.sv
src/stps_seq.sv
src/sleep_timer_process_scheduler.sv
tb/sv/sleep_timer_process_scheduler_test.sv
